// ----- rtl/nrpn_pkg.sv -----
// Shared types, register indexes and reset values for the resize/pad/normalize block.
package nrpn_pkg;

  // Default frame store geometry
  localparam int DEF_MAX_SRC_WIDTH  = 1024;
  localparam int DEF_MAX_SRC_HEIGHT = 1024;

  // Depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 8;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_SIZE  = 4'd0,
    CFG_COL_STEP     = 4'd1,
    CFG_ROW_STEP     = 4'd2,
    CFG_SHIFT_X      = 4'd3,
    CFG_SHIFT_Y      = 4'd4,
    CFG_GAIN_TABLE   = 4'd5,
    CFG_OFFSET_TABLE = 4'd6,
    CFG_PAD_AND_SWAP = 4'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [21:0] SOURCE_SIZE_RST = 22'd2098176;   // 1024 x 1024
  localparam logic [23:0] INV_SCALE_RST   = 24'h01_0000;   // 1.0 in Q8.16
  localparam logic [47:0] GAIN_TABLE_RST  = 48'h4000_4000_4000; // 1.0 in Q2.14

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  // Result pad classification codes
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_COL  = 2'd1;
  localparam logic [1:0] PAD_ROW  = 2'd2;

  // Work classified by the front part
  typedef enum logic [1:0] {
    JOB_WRITE   = 2'd0,
    JOB_SOURCE  = 2'd1,
    JOB_COL_PAD = 2'd2,
    JOB_ROW_PAD = 2'd3
  } job_kind_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [9:0]  src_col;
    logic [9:0]  src_row;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [7:0]  byte_third;
    logic [11:0] dst_col;
    logic [11:0] dst_row;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_col;
    logic [11:0]        out_row;
    logic signed [23:0] plane_zero;
    logic signed [23:0] plane_one;
    logic signed [23:0] plane_two;
    logic [1:0]         pad_kind;
  } out_item_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] pixel;
  } job_t;

  typedef struct packed {
    logic [21:0]        source_size;
    logic [23:0]        col_step;
    logic [23:0]        row_step;
    logic signed [28:0] shift_x;
    logic signed [28:0] shift_y;
    logic [47:0]        gain_table;
    logic [47:0]        offset_table;
    logic [16:0]        pad_and_swap;
  } cfg_t;

endpackage

// ----- rtl/nrpn_fifo.sv -----
// Small register queue between the front and back parts.
module nrpn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // Pointer and fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = entry_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

// ----- rtl/nrpn_front.sv -----
// Front part: takes items, maps destination coordinates and classifies the work.
module nrpn_front #(
  parameter int MAX_SRC_WIDTH  = nrpn_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = nrpn_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int AW             = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  nrpn_pkg::in_item_t in_item,
  input  nrpn_pkg::cfg_t    cfg,
  output logic              push,
  output nrpn_pkg::job_t    job,
  output logic [AW-1:0]     addr,
  output logic [1:0]        occupancy
);

  localparam int CW     = $clog2(MAX_SRC_WIDTH);
  localparam int RW     = $clog2(MAX_SRC_HEIGHT);
  localparam int PROD_W = 36;
  localparam int POS_W  = 38;
  localparam int SIZE_W = 13;

  // Stage 1: coordinate times inverse scale
  logic                  s1_valid_r;
  nrpn_pkg::in_item_t    s1_item_r;
  logic [PROD_W-1:0]     s1_prod_x_r;
  logic [PROD_W-1:0]     s1_prod_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_item_r   <= in_item;
    s1_prod_x_r <= PROD_W'(in_item.dst_col) * PROD_W'(cfg.col_step);
    s1_prod_y_r <= PROD_W'(in_item.dst_row) * PROD_W'(cfg.row_step);
  end

  // Stage 2: subtract shift, range check, classify
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] limit_x;
  logic signed [POS_W-1:0] limit_y;
  logic [SIZE_W-1:0]       w_raw;
  logic [SIZE_W-1:0]       h_raw;
  logic [SIZE_W-1:0]       w_sat;
  logic [SIZE_W-1:0]       h_sat;
  logic                    out_x;
  logic                    out_y;
  logic [SIZE_W-1:0]       wr_col_ext;
  logic [SIZE_W-1:0]       wr_row_ext;
  logic                    wr_ok;
  logic                    s2_keep;
  nrpn_pkg::job_t          s2_job;
  logic [CW-1:0]           s2_idx_x;
  logic [RW-1:0]           s2_idx_y;

  always_comb begin
    pos_x   = $signed({2'b00, s1_prod_x_r}) - POS_W'(cfg.shift_x);
    pos_y   = $signed({2'b00, s1_prod_y_r}) - POS_W'(cfg.shift_y);
    w_raw   = {2'b00, cfg.source_size[10:0]};
    h_raw   = {2'b00, cfg.source_size[21:11]};
    // sizes beyond the store saturate to its limit
    w_sat   = (w_raw > SIZE_W'(MAX_SRC_WIDTH))  ? SIZE_W'(MAX_SRC_WIDTH)  : w_raw;
    h_sat   = (h_raw > SIZE_W'(MAX_SRC_HEIGHT)) ? SIZE_W'(MAX_SRC_HEIGHT) : h_raw;
    limit_x = $signed(POS_W'({w_sat, 16'h0000}));
    limit_y = $signed(POS_W'({h_sat, 16'h0000}));
    out_x   = pos_x[POS_W-1] || (pos_x >= limit_x);
    out_y   = pos_y[POS_W-1] || (pos_y >= limit_y);

    wr_col_ext = {3'b000, s1_item_r.src_col};
    wr_row_ext = {3'b000, s1_item_r.src_row};
    wr_ok = (wr_col_ext < SIZE_W'(MAX_SRC_WIDTH)) && (wr_row_ext < SIZE_W'(MAX_SRC_HEIGHT));

    s2_job.col   = s1_item_r.dst_col;
    s2_job.row   = s1_item_r.dst_row;
    s2_job.pixel = {s1_item_r.byte_third, s1_item_r.byte_second, s1_item_r.byte_first};

    if (s1_item_r.opcode == nrpn_pkg::OP_WRITE) begin
      // writes beyond the store are dropped here
      s2_job.kind = nrpn_pkg::JOB_WRITE;
      s2_keep     = wr_ok;
      s2_idx_x    = wr_col_ext[CW-1:0];
      s2_idx_y    = wr_row_ext[RW-1:0];
    end else begin
      s2_keep  = 1'b1;
      s2_idx_x = pos_x[16 +: CW];
      s2_idx_y = pos_y[16 +: RW];
      if (out_y) begin
        s2_job.kind = nrpn_pkg::JOB_ROW_PAD;
      end else if (out_x) begin
        s2_job.kind = nrpn_pkg::JOB_COL_PAD;
      end else begin
        s2_job.kind = nrpn_pkg::JOB_SOURCE;
      end
    end
  end

  logic           s2_valid_r;
  nrpn_pkg::job_t s2_job_r;
  logic [CW-1:0]  s2_idx_x_r;
  logic [RW-1:0]  s2_idx_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s2_keep;
    end
    s2_job_r   <= s2_job;
    s2_idx_x_r <= s2_idx_x;
    s2_idx_y_r <= s2_idx_y;
  end

  // Stage 3: linear store address
  logic           s3_valid_r;
  nrpn_pkg::job_t s3_job_r;
  logic [AW-1:0]  s3_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_job_r  <= s2_job_r;
    s3_addr_r <= AW'(s2_idx_y_r) * AW'(MAX_SRC_WIDTH) + AW'(s2_idx_x_r);
  end

  assign push      = s3_valid_r;
  assign job       = s3_job_r;
  assign addr      = s3_addr_r;
  assign occupancy = {1'b0, s1_valid_r} + {1'b0, s2_valid_r} + {1'b0, s3_valid_r};

endmodule

// ----- rtl/nrpn_back.sv -----
// Back part: frame store access, channel select, normalization and result register.
module nrpn_back #(
  parameter int MAX_SRC_WIDTH  = nrpn_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = nrpn_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int AW             = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  nrpn_pkg::job_t      job_in,
  input  logic [AW-1:0]       addr_in,
  input  nrpn_pkg::cfg_t      cfg,
  output logic                out_valid,
  output nrpn_pkg::out_item_t out_item
);

  localparam int MEM_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int VAL_W     = 17;
  localparam int PRD_W     = 33;
  localparam int ACC_W     = 35;
  localparam int RND_W     = ACC_W - 10;

  // Frame store: one write or one read per item, read data registered
  logic [23:0]    store_mem [MEM_DEPTH];
  logic [23:0]    rdata_r;
  logic           b1_valid_r;
  nrpn_pkg::job_t b1_job_r;

  always_ff @(posedge clk) begin
    if (job_valid && (job_in.kind == nrpn_pkg::JOB_WRITE)) begin
      store_mem[addr_in] <= job_in.pixel;
    end
    rdata_r <= store_mem[addr_in];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else begin
      b1_valid_r <= job_valid && (job_in.kind != nrpn_pkg::JOB_WRITE);
    end
    b1_job_r <= job_in;
  end

  // Channel select and gain multiply
  logic signed [15:0]      pad;
  logic [7:0]              ch_byte [3];
  logic signed [VAL_W-1:0] ch_val  [3];
  logic signed [15:0]      ch_gain [3];

  always_comb begin
    pad = $signed(cfg.pad_and_swap[16:1]);
    for (int c = 0; c < 3; c++) begin
      ch_byte[c] = cfg.pad_and_swap[0] ? rdata_r[8*(2-c) +: 8] : rdata_r[8*c +: 8];
      ch_gain[c] = $signed(cfg.gain_table[16*c +: 16]);
      if (b1_job_r.kind == nrpn_pkg::JOB_SOURCE) begin
        ch_val[c] = $signed({1'b0, ch_byte[c], 8'h00});
      end else begin
        ch_val[c] = VAL_W'(pad);
      end
    end
  end

  logic                    b2_valid_r;
  nrpn_pkg::job_t          b2_job_r;
  logic signed [PRD_W-1:0] b2_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else begin
      b2_valid_r <= b1_valid_r;
    end
    b2_job_r <= b1_job_r;
    for (int c = 0; c < 3; c++) begin
      b2_prod_r[c] <= PRD_W'(ch_val[c]) * PRD_W'(ch_gain[c]);
    end
  end

  // Offset, round half up to Q.12, saturate
  logic signed [ACC_W-1:0] acc [3];
  logic signed [RND_W-1:0] rnd [3];
  logic signed [23:0]      sat [3];
  logic signed [15:0]      ch_off [3];
  logic signed [23:0]      raw_pad;
  logic [1:0]              kind_code;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_off[c] = $signed(cfg.offset_table[16*c +: 16]);
      acc[c] = ACC_W'(b2_prod_r[c]) + (ACC_W'(ch_off[c]) <<< 12) + ACC_W'(512);
      rnd[c] = acc[c][ACC_W-1:10];
      if (rnd[c] > RND_W'(8388607)) begin
        sat[c] = 24'sh7F_FFFF;
      end else if (rnd[c] < -RND_W'(8388608)) begin
        sat[c] = -24'sh80_0000;
      end else begin
        sat[c] = rnd[c][23:0];
      end
    end
    // row outside: pad passed through unnormalized
    raw_pad = {{4{pad[15]}}, pad, 4'h0};
    case (b2_job_r.kind)
      nrpn_pkg::JOB_COL_PAD: kind_code = nrpn_pkg::PAD_COL;
      nrpn_pkg::JOB_ROW_PAD: kind_code = nrpn_pkg::PAD_ROW;
      default:               kind_code = nrpn_pkg::PAD_NONE;
    endcase
  end

  logic                out_valid_r;
  nrpn_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b2_valid_r;
    end
    out_item_r.out_col  <= b2_job_r.col;
    out_item_r.out_row  <= b2_job_r.row;
    out_item_r.pad_kind <= kind_code;
    if (b2_job_r.kind == nrpn_pkg::JOB_ROW_PAD) begin
      out_item_r.plane_zero <= raw_pad;
      out_item_r.plane_one  <= raw_pad;
      out_item_r.plane_two  <= raw_pad;
    end else begin
      out_item_r.plane_zero <= sat[0];
      out_item_r.plane_one  <= sat[1];
      out_item_r.plane_two  <= sat[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/nearest_resize_pad_normalize.sv -----
// Top level: configuration registers, front part, queue and back part.
//
// Nearest-neighbour resize with letterbox padding and per-channel normalization.
// One item (a frame store write or a destination pixel) is taken every clock cycle
// while busy is low. A compute item gives its result, marked by out_valid for one
// cycle, after passing both parts and the queue; writes give none and results keep
// item order. Throughput is set by the single-port frame store, which does one
// access per item; the front mapping (multiply, range check, address) and the
// back normalization (gain multiply, offset and saturation) are pipelined around
// it. busy rises only when the queue between the two parts could not take
// everything in flight. The frame store needs no clearing after reset; an entry
// must be written before it is read. Configuration must be written only while no
// item is in flight (not enforced); an index beyond the register list is ignored.
module nearest_resize_pad_normalize #(
  parameter int MAX_SRC_WIDTH  = nrpn_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = nrpn_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  nrpn_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  output nrpn_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [nrpn_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nrpn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
  localparam int JOB_W = $bits(nrpn_pkg::job_t);
  localparam int QW    = JOB_W + AW;
  localparam int CNT_W = $clog2(nrpn_pkg::QUEUE_DEPTH + 1);
  localparam int BW    = CNT_W + 1;

  // Configuration registers
  nrpn_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_size  <= nrpn_pkg::SOURCE_SIZE_RST;
      cfg_r.col_step     <= nrpn_pkg::INV_SCALE_RST;
      cfg_r.row_step     <= nrpn_pkg::INV_SCALE_RST;
      cfg_r.shift_x      <= '0;
      cfg_r.shift_y      <= '0;
      cfg_r.gain_table   <= nrpn_pkg::GAIN_TABLE_RST;
      cfg_r.offset_table <= '0;
      cfg_r.pad_and_swap <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nrpn_pkg::CFG_SOURCE_SIZE:  cfg_r.source_size  <= cfg_data[21:0];
        nrpn_pkg::CFG_COL_STEP:     cfg_r.col_step     <= cfg_data[23:0];
        nrpn_pkg::CFG_ROW_STEP:     cfg_r.row_step     <= cfg_data[23:0];
        nrpn_pkg::CFG_SHIFT_X:      cfg_r.shift_x      <= cfg_data[28:0];
        nrpn_pkg::CFG_SHIFT_Y:      cfg_r.shift_y      <= cfg_data[28:0];
        nrpn_pkg::CFG_GAIN_TABLE:   cfg_r.gain_table   <= cfg_data[47:0];
        nrpn_pkg::CFG_OFFSET_TABLE: cfg_r.offset_table <= cfg_data[47:0];
        nrpn_pkg::CFG_PAD_AND_SWAP: cfg_r.pad_and_swap <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Input transfer
  logic accept;
  assign accept = start && !busy;

  logic           f_push;
  nrpn_pkg::job_t f_job;
  logic [AW-1:0]  f_addr;
  logic [1:0]     f_occupancy;

  nrpn_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .AW             (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .push      (f_push),
    .job       (f_job),
    .addr      (f_addr),
    .occupancy (f_occupancy)
  );

  // Queue between front and back; the back drains one entry per cycle
  logic [QW-1:0]    q_pop_data;
  logic             q_empty;
  logic [CNT_W-1:0] q_count;
  logic             q_pop;

  assign q_pop = !q_empty;

  nrpn_fifo #(
    .WIDTH (QW),
    .DEPTH (nrpn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_job, f_addr}),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  // Hold off input when queued plus in-flight work could overrun the queue
  assign busy = (BW'(q_count) + BW'(f_occupancy)) >= BW'(nrpn_pkg::QUEUE_DEPTH);

  nrpn_pkg::job_t b_job;
  logic [AW-1:0]  b_addr;

  assign b_job  = q_pop_data[QW-1 -: JOB_W];
  assign b_addr = q_pop_data[AW-1:0];

  nrpn_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .AW             (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop),
    .job_in    (b_job),
    .addr_in   (b_addr),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

// ----- rtl/nrpn_checker.sv -----
// Port-level checks for the resize/pad/normalize block, bound to the top level.
module nrpn_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input nrpn_pkg::in_item_t               in_data,
  input logic                             out_valid,
  input nrpn_pkg::out_item_t              out_data
);

  localparam int LAT = 7;

  // A compute transfer returns its coordinate after the fixed latency
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == nrpn_pkg::OP_COMPUTE) |-> ##LAT
      (out_valid && out_data.out_col == $past(in_data.dst_col, LAT)
                 && out_data.out_row == $past(in_data.dst_row, LAT)))
    else $error("compute transfer did not give its result on time");

  // A write transfer gives no result
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == nrpn_pkg::OP_WRITE) |-> ##LAT !out_valid)
    else $error("write transfer produced a result");

  // Every result traces back to a compute transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      $past(rst_n && start && !busy && in_data.opcode == nrpn_pkg::OP_COMPUTE, LAT))
    else $error("result without a compute transfer");

  // Row padding repeats the raw pad on all planes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pad_kind == nrpn_pkg::PAD_ROW) |->
      (out_data.plane_zero == out_data.plane_one &&
       out_data.plane_one == out_data.plane_two &&
       out_data.plane_zero[3:0] == 4'h0))
    else $error("row pad planes differ");

endmodule

bind nearest_resize_pad_normalize nrpn_checker u_nrpn_checker (.*);
